@@ hdl/sipq_pkg.sv @@
package sipq_pkg;

   typedef enum logic [1:0] {
      FUNC_ENQ  = 2'd0,
      FUNC_DEQ  = 2'd1,
      FUNC_PEEK = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int IdWidth    = 16;
   localparam int StampWidth = 16;
   localparam int FillWidth  = 4;

   typedef struct packed {
      logic                  valid;
      logic [IdWidth-1:0]    id;
      logic [StampWidth-1:0] stamp;
   } entry_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic                  enq;
      logic                  deq;
      logic [IdWidth-1:0]    id;
      logic [StampWidth-1:0] stamp;
   } cmd_type;

endpackage

@@ hdl/sipq_cell.sv @@
module sipq_cell (
   input  logic                clock,
   input  logic                reset,
   input  sipq_pkg::cmd_type   cmd,
   input  sipq_pkg::entry_type left_entry,
   input  logic                left_ins,
   input  sipq_pkg::entry_type right_entry,
   output sipq_pkg::entry_type entry,
   output logic                ins
);
   import sipq_pkg::*;

   logic                  valid_ff, valid_in;
   logic [IdWidth-1:0]    id_ff, id_in;
   logic [StampWidth-1:0] stamp_ff, stamp_in;

   assign entry = '{valid: valid_ff, id: id_ff, stamp: stamp_ff};

   // new word belongs at or before this cell (strict compare keeps equal keys stable)
   assign ins = !valid_ff || (cmd.stamp < stamp_ff);

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      stamp_in = stamp_ff;
      if (cmd.deq) begin
         valid_in = right_entry.valid;
         id_in    = right_entry.id;
         stamp_in = right_entry.stamp;
      end else if (cmd.enq && ins) begin
         if (left_ins) begin
            valid_in = left_entry.valid;
            id_in    = left_entry.id;
            stamp_in = left_entry.stamp;
         end else begin
            valid_in = 1'b1;
            id_in    = cmd.id;
            stamp_in = cmd.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff    <= id_in;
      stamp_ff <= stamp_in;
   end

endmodule

@@ hdl/sorted_insert_priority_queue.sv @@
// Sorted priority queue of up to DEPTH (id, start time) words, head = smallest time,
// equal times leave in arrival order. One request is accepted per cycle, unless a
// stalled response holds the input; each gives one response in the next cycle, held
// in an output register. A row of DEPTH cells compares the new time against every
// stored word at once and shifts; the compare plus shift mux sets the clock period.
module sorted_insert_priority_queue #(
   parameter int DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_proc_id,
   input  logic [15:0] req_start_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_head_id,
   output logic [15:0] rsp_head_time,
   output logic [3:0]  rsp_fill_level
);
   import sipq_pkg::*;

   localparam int CountWidth = $clog2(DEPTH + 1);

   entry_type          entries  [DEPTH];
   logic               ins_flags[DEPTH];
   cmd_type            cmd;
   logic               accept;
   logic               full;
   logic               empty;
   logic               enq_ok;
   logic               deq_ok;
   logic [CountWidth-1:0] count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic [15:0]        head_id_ff, head_id_in;
   logic [15:0]        head_time_ff, head_time_in;
   logic [3:0]         fill_ff, fill_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CountWidth'(DEPTH));
   assign empty     = (count_ff == '0);
   assign enq_ok    = accept && (req_func == FUNC_ENQ) && !full;
   assign deq_ok    = accept && (req_func == FUNC_DEQ) && !empty;

   assign cmd = '{enq: enq_ok, deq: deq_ok, id: req_proc_id, stamp: req_start_time};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_i;
      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_i = 1'b0;
      end else begin : g_mid
         assign left_e = entries[i-1];
         assign left_i = ins_flags[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = entries[i+1];
      end
      sipq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_e),
         .left_ins    (left_i),
         .right_entry (right_e),
         .entry       (entries[i]),
         .ins         (ins_flags[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + 1'b1;
      end else if (deq_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      status_in    = STATUS_OK;
      head_id_in   = '0;
      head_time_in = '0;
      unique case (req_func)
         FUNC_ENQ: begin
            if (full) begin
               status_in = STATUS_FULL;
            end
         end
         FUNC_DEQ, FUNC_PEEK: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               head_id_in   = entries[0].id;
               head_time_in = entries[0].stamp;
            end
         end
         default: begin
         end
      endcase
      fill_in = 4'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         status_ff    <= status_in;
         head_id_ff   <= head_id_in;
         head_time_ff <= head_time_in;
         fill_ff      <= fill_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_head_id    = head_id_ff;
   assign rsp_head_time  = head_time_ff;
   assign rsp_fill_level = fill_ff;

endmodule

@@ hdl/sipq_checker.sv @@
module sipq_checker #(
   parameter int DEPTH = 8
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_head_id,
   input logic [15:0] rsp_head_time,
   input logic [3:0]  rsp_fill_level
);
   import sipq_pkg::*;

   // input only waits behind an unclaimed response
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   a_full_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |->
         (rsp_fill_level == 4'(DEPTH)) && (rsp_head_id == '0) && (rsp_head_time == '0))
      else $error("full response with wrong fill or head");

   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |->
         (rsp_fill_level == '0) && (rsp_head_id == '0) && (rsp_head_time == '0))
      else $error("empty response with wrong fill or head");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

endmodule

bind sorted_insert_priority_queue sipq_checker #(.DEPTH(DEPTH)) u_sipq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_head_id    (rsp_head_id),
   .rsp_head_time  (rsp_head_time),
   .rsp_fill_level (rsp_fill_level)
);
